[rtl/dnle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dnle_pkg;

  localparam int BYTE_W = 8;
  localparam logic [BYTE_W-1:0] DOT_CHAR = 8'd46;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA
  } dnle_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              root_follows;
    logic              label_overflow;
  } dnle_beat_t;

endpackage
`default_nettype wire

[rtl/dnle_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dnle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       end_of_name;

  modport source (output valid, output name_char, output end_of_name, input ready);
  modport sink (input valid, input name_char, input end_of_name, output ready);
endinterface
`default_nettype wire

[rtl/dnle_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface dnle_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       root_follows;
  logic       label_overflow;

  modport source (output valid, output out_byte, output run_last, output root_follows,
                  output label_overflow, input ready);
  modport sink (input valid, input out_byte, input run_last, input root_follows,
                input label_overflow, output ready);
endinterface
`default_nettype wire

[rtl/dnle_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module dnle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 63,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/dnle_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module dnle_out_reg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                load,
  input  wire dnle_pkg::dnle_beat_t beat,
  output logic                     slot_free,
  dnle_out_if.source               out_ch
);
  import dnle_pkg::*;

  logic       valid_r, valid_nxt;
  dnle_beat_t beat_r;

  assign slot_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      beat_r <= beat;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.out_byte       = beat_r.out_byte;
  assign out_ch.run_last       = beat_r.run_last;
  assign out_ch.root_follows   = beat_r.root_follows;
  assign out_ch.label_overflow = beat_r.label_overflow;

endmodule
`default_nettype wire

[rtl/dns_name_label_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  payload                                             handshake
// in_ch    in   name_char[7:0], end_of_name                         valid/ready
// out_ch   out  out_byte[7:0], run_last, root_follows, label_overflow  valid/ready
//
// a plain character fills the label ram; past LABEL_MAX it is dropped and flagged
// a dot or end of name flushes the label: n+1 bytes leave, the length byte first,
//   one byte per cycle unless out_ch stalls, paced by the single ram read port
// new characters are taken only between flushes; a flush may start while the
//   last byte of the previous one still waits in the output register
// synchronous active-low reset clears count, overflow flag and fsm; ram is not cleared
module dns_name_label_encoder_core #(
  parameter int LABEL_MAX = 63
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dnle_in_if.sink    in_ch,
  dnle_out_if.source out_ch
);
  import dnle_pkg::*;

  localparam int CNT_W  = $clog2(LABEL_MAX + 1);
  localparam int ADDR_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

  dnle_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] idx_inc;
  logic             ovf_r, ovf_nxt;
  logic             end_r, end_nxt;

  logic              in_fire;
  logic              is_dot;
  logic              we, re;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic              load, slot_free, last;
  dnle_beat_t        beat;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign is_dot      = (in_ch.name_char == DOT_CHAR);
  assign idx_inc     = idx_r + 1'b1;
  assign last        = (idx_inc == count_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    ovf_nxt     = ovf_r;
    end_nxt     = end_r;
    we          = 1'b0;
    re          = 1'b0;
    rd_addr     = idx_inc[ADDR_W-1:0];
    load        = 1'b0;
    beat        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_dot) begin
            if (count_r < CNT_W'(LABEL_MAX)) begin
              we        = 1'b1;
              count_nxt = count_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (is_dot || in_ch.end_of_name) begin
            end_nxt   = in_ch.end_of_name;
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (slot_free) begin
          load                = 1'b1;
          beat.out_byte       = BYTE_W'(count_r);
          beat.run_last       = (count_r == '0);
          beat.root_follows   = end_r && (count_r == '0);
          beat.label_overflow = ovf_r;
          if (count_r == '0) begin
            state_nxt = ST_IDLE;
            if (end_r) begin
              ovf_nxt = 1'b0;
            end
          end else begin
            // prefetch the first character
            re        = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          load                = 1'b1;
          beat.out_byte       = rd_data;
          beat.run_last       = last;
          beat.root_follows   = end_r && last;
          beat.label_overflow = ovf_r;
          if (last) begin
            count_nxt = '0;
            state_nxt = ST_IDLE;
            if (end_r) begin
              ovf_nxt = 1'b0;
            end
          end else begin
            re      = 1'b1;
            idx_nxt = idx_inc;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      ovf_r   <= 1'b0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      ovf_r   <= ovf_nxt;
      end_r   <= end_nxt;
    end
  end

  dnle_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (LABEL_MAX),
    .AW    (ADDR_W)
  ) u_label_ram (
    .clk   (clk),
    .we    (we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_ch.name_char),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  dnle_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .beat      (beat),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LABEL_MAX))
    else $error("label count above maximum");

  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DATA |-> idx_r < count_r)
    else $error("read index beyond buffered label");

  a_root_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.root_follows |-> out_ch.run_last)
    else $error("root marker off the last byte of a run");

  a_name_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load && slot_free && beat.root_follows |=> !ovf_r && count_r == '0)
    else $error("state not cleared at end of name");

endmodule
`default_nettype wire

[tb/dns_name_label_encoder_core_tb.sv]
`timescale 1ns / 1ps
module dns_name_label_encoder_core_tb;
  import dnle_pkg::*;

  localparam int LABEL_MAX    = 63;
  localparam int ITEMS_TARGET = 430;
  localparam int MAX_RESULTS  = 64;
  localparam int MAX_GAP      = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 2 * LABEL_MAX + 8;
  localparam int CYCLE_LIMIT  =
    4 * (ITEMS_TARGET + 100) * (MAX_RESULTS * (MAX_GAP + 1) + MAX_GAP + 2) + 10000;
  localparam int PRINT_CAP    = 50;

  logic clk = 1'b0;
  logic rst_n;

  dnle_in_if  in_bus ();
  dnle_out_if out_bus ();

  dns_name_label_encoder_core #(
    .LABEL_MAX(LABEL_MAX)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus.sink),
    .out_ch(out_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the encoder state
  logic [7:0] label_buf [0:LABEL_MAX-1];
  logic [5:0] label_len;
  logic       ovf_flag;
  dnle_beat_t wire_bytes_q [$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b0;
  bit  hold_on = 1'b0;
  event hold_ev;

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want,
               cycle_count);
  endtask

  task automatic push_beat(input logic [7:0] b, input logic last, input logic root);
    dnle_beat_t beat;
    beat.out_byte       = b;
    beat.run_last       = last;
    beat.root_follows   = root;
    beat.label_overflow = ovf_flag;
    wire_bytes_q.push_back(beat);
  endtask

  task automatic flush_label(input logic at_end);
    int n;
    n = label_len;
    push_beat(8'(n), n == 0, at_end && n == 0);
    for (int i = 0; i < n; i++)
      push_beat(label_buf[i], i == n - 1, at_end && i == n - 1);
    label_len = '0;
  endtask

  task automatic encode_char(input logic [7:0] c, input logic eon);
    if (c != DOT_CHAR) begin
      if (label_len < LABEL_MAX) begin
        label_buf[label_len] = c;
        label_len = label_len + 6'd1;
      end else begin
        ovf_flag = 1'b1;
      end
      if (eon) flush_label(1'b1);
    end else begin
      flush_label(eon);
    end
    if (eon) begin
      label_len = '0;
      ovf_flag  = 1'b0;
    end
  endtask

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, MAX_GAP);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, MAX_GAP);
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == DOT_CHAR) c = c ^ 8'h01;
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eon);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.name_char   <= c;
    in_bus.end_of_name <= eon;
    forever begin
      @(posedge clk);
      if (in_bus.ready) break;
    end
    encode_char(c, eon);
    items_sent++;
  endtask

  task automatic release_input();
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (wire_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_label(input int len, input logic eon_on_last);
    for (int i = 0; i < len; i++)
      send_char(label_char(), eon_on_last && i == len - 1);
  endtask

  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 88) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 40);
    return $urandom_range(LABEL_MAX - 3, LABEL_MAX + 3);
  endfunction

  task automatic send_random_name();
    int  labels;
    int  len;
    bit  trailing;
    labels   = $urandom_range(1, 4);
    trailing = ($urandom_range(0, 5) == 0);
    for (int j = 0; j < labels; j++) begin
      len = pick_label_len();
      if (j < labels - 1) begin
        send_label(len, 1'b0);
        send_char(DOT_CHAR, 1'b0);
      end else if (trailing || len == 0) begin
        send_label(len, 1'b0);
        send_char(DOT_CHAR, 1'b1);
      end else begin
        send_label(len, 1'b1);
      end
    end
  endtask

  task automatic send_noise();
    logic [7:0] c;
    repeat ($urandom_range(1, 12)) begin
      c = ($urandom_range(0, 3) == 0) ? DOT_CHAR : 8'($urandom_range(0, 255));
      send_char(c, $urandom_range(0, 5) == 0);
    end
  endtask

  task automatic test_single_labels();
    idle_on = 1'b0;
    send_text("a");
    send_text("ab.c");
  endtask

  task automatic test_empty_labels();
    idle_on = 1'b1;
    send_text(".");
    send_text(".x");
    send_text("a..b");
  endtask

  task automatic test_trailing_dot();
    send_text("a.b.");
  endtask

  task automatic test_byte_extremes();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'haa, 1'b0);
    send_char(8'h55, 1'b1);
    send_char(8'hff, 1'b1);
  endtask

  task automatic test_label_overflow();
    // exactly at the limit, then two past it, overflow carrying into the next label
    send_label(LABEL_MAX, 1'b0);
    send_char(DOT_CHAR, 1'b0);
    send_char(label_char(), 1'b1);
    send_label(LABEL_MAX + 2, 1'b0);
    send_char(DOT_CHAR, 1'b0);
    send_char(label_char(), 1'b1);
    // dropped character carries the end flag
    send_label(LABEL_MAX + 1, 1'b1);
    send_text("ok");
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    -> hold_ev;
    repeat (3) send_random_name();
    wait_drained();
    idle_on = 1'b1;
    repeat (2) send_random_name();
    wait_drained();
    repeat (2) send_random_name();
  endtask

  task automatic test_random_names();
    while (items_sent < ITEMS_TARGET) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 99) < 85) send_random_name();
      else send_noise();
    end
    send_text("z");
  endtask

  // long receiver hold-off, timed in its own process
  initial begin
    forever begin
      @(hold_ev);
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_on) begin
      out_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left    <= stall_len() - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    dnle_beat_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (wire_bytes_q.size() == 0) begin
        report_mismatch("unexpected byte", out_bus.out_byte, 8'h00);
      end else begin
        want = wire_bytes_q.pop_front();
        if (out_bus.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_bus.out_byte, want.out_byte);
        if (out_bus.run_last !== want.run_last)
          report_mismatch("run_last", 8'(out_bus.run_last), 8'(want.run_last));
        if (out_bus.root_follows !== want.root_follows)
          report_mismatch("root_follows", 8'(out_bus.root_follows),
                          8'(want.root_follows));
        if (out_bus.label_overflow !== want.label_overflow)
          report_mismatch("label_overflow", 8'(out_bus.label_overflow),
                          8'(want.label_overflow));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dns_name_label_encoder_core test failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.name_char   = 8'h00;
    in_bus.end_of_name = 1'b0;
    out_bus.ready      = 1'b0;
    label_len          = '0;
    ovf_flag           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_labels();
    test_empty_labels();
    test_trailing_dot();
    test_byte_extremes();
    test_label_overflow();
    test_backpressure();
    test_random_names();

    idle_on = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && wire_bytes_q.size() == 0) begin
      $display("dns_name_label_encoder_core test passed");
    end else begin
      $display("dns_name_label_encoder_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dnle_pkg.sv
rtl/dnle_in_if.sv
rtl/dnle_out_if.sv
rtl/dnle_ram.sv
rtl/dnle_out_reg.sv
rtl/dns_name_label_encoder_core.sv
tb/dns_name_label_encoder_core_tb.sv
